[sv/step_mash_temperature_sequencer_macros.svh]
// Assertion macros for the step mash temperature sequencer.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef STEP_MASH_TEMPERATURE_SEQUENCER_MACROS_SVH
`define STEP_MASH_TEMPERATURE_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SMTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SMTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/smts_pkg.sv]
// Package for the step mash temperature sequencer: stage codes, register
// indexes, reset values and beat payload types. No dependencies.
package smts_pkg;

	typedef enum logic [2:0] {
		ST_HEAT1 = 3'd0,
		ST_MALT  = 3'd1,
		ST_HOLD1 = 3'd2,
		ST_HEAT2 = 3'd3,
		ST_HOLD2 = 3'd4,
		ST_HEAT3 = 3'd5,
		ST_HOLD3 = 3'd6,
		ST_DONE  = 3'd7
	} stage_t;

	typedef enum logic [2:0] {
		CFG_TARGET_ONE   = 3'd0,
		CFG_TARGET_TWO   = 3'd1,
		CFG_TARGET_THREE = 3'd2,
		CFG_HOLD_ONE     = 3'd3,
		CFG_HOLD_TWO     = 3'd4,
		CFG_HOLD_THREE   = 3'd5,
		CFG_ALARM_LEAD   = 3'd6
	} cfg_idx_t;

	localparam logic [6:0] TARGET_ONE_RST   = 7'd24;
	localparam logic [6:0] TARGET_TWO_RST   = 7'd26;
	localparam logic [6:0] TARGET_THREE_RST = 7'd27;
	localparam logic [7:0] HOLD_ONE_RST     = 8'd1;
	localparam logic [7:0] HOLD_TWO_RST     = 8'd1;
	localparam logic [7:0] HOLD_THREE_RST   = 8'd1;
	localparam logic [7:0] ALARM_LEAD_RST   = 8'd2;

	localparam logic [16:0] MILLI_PER_DEG = 17'd1000;
	localparam logic [5:0]  LAST_SEC      = 6'd59;
	localparam logic [5:0]  LAST_MIN      = 6'd59;
	localparam logic [4:0]  MAX_HOURS     = 5'd31;

	typedef struct packed {
		logic signed [17:0] temp_milli;
		logic               button_pressed;
		logic               second_tick;
	} sample_t;

	typedef struct packed {
		logic       heater_on;
		logic       malt_prompt;
		logic       sparge_alarm;
		logic [2:0] stage;
		logic [4:0] hold_hours;
		logic [5:0] hold_minutes;
		logic [5:0] hold_secs;
		logic       done_res;
	} result_t;

	typedef struct packed {
		logic [2:0] addr;
		logic [7:0] wdata;
	} cfg_wr_t;

	// Hold timer control: step on a processed item, tick to count, clear on
	// a stage change.
	typedef struct packed {
		logic step;
		logic tick;
		logic clear;
	} hold_ctl_t;

endpackage

[sv/smts_if.sv]
// Valid/ready channel interfaces for samples, results and register writes.
// Depends on smts_pkg for the payload types.
interface smts_in_if import smts_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface smts_out_if import smts_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface smts_cfg_if import smts_pkg::*; ();
	logic    valid;
	logic    ready;
	cfg_wr_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/smts_hold_timer.sv]
// Hold stage timer: saturating seconds count kept alongside an
// hours/minutes/seconds breakdown. Depends on smts_pkg.
module smts_hold_timer import smts_pkg::*; #(
	parameter int COUNTER_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hold_ctl_t               ctl,
	output logic [COUNTER_BITS-1:0] count_next,
	output logic [4:0]              hours_next,
	output logic [5:0]              minutes_next,
	output logic [5:0]              secs_next
);

	logic [COUNTER_BITS-1:0] count_q;
	logic [4:0]              hours_q;
	logic [5:0]              minutes_q;
	logic [5:0]              secs_q;
	logic                    inc;

	assign inc = ctl.tick && (count_q != {COUNTER_BITS{1'b1}});

	always_comb begin
		count_next   = count_q;
		hours_next   = hours_q;
		minutes_next = minutes_q;
		secs_next    = secs_q;
		if (inc) begin
			count_next = count_q + 1'b1;
			if (secs_q == LAST_SEC) begin
				secs_next = '0;
				if (minutes_q == LAST_MIN) begin
					minutes_next = '0;
					// hours stick at the top; minutes and seconds keep rolling
					if (hours_q != MAX_HOURS)
						hours_next = hours_q + 1'b1;
				end else begin
					minutes_next = minutes_q + 1'b1;
				end
			end else begin
				secs_next = secs_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			hours_q   <= '0;
			minutes_q <= '0;
			secs_q    <= '0;
		end else if (ctl.step) begin
			if (ctl.clear) begin
				count_q   <= '0;
				hours_q   <= '0;
				minutes_q <= '0;
				secs_q    <= '0;
			end else begin
				count_q   <= count_next;
				hours_q   <= hours_next;
				minutes_q <= minutes_next;
				secs_q    <= secs_next;
			end
		end
	end

endmodule

[sv/step_mash_temperature_sequencer.sv]
// Step mash temperature sequencer, top level.
// Channels: sample (sink) carries temp_milli, button_pressed, second_tick;
// result (source) carries one result beat per sample beat; cfg (sink)
// writes the seven profile registers by index and is always ready.
// A sample beat lands in an input register; the stage logic runs on it
// there and loads the result register when it is empty or being read.
// One sample per cycle is sustained while the receiver takes each result:
// the state update and result fit between the input and result registers,
// and the input register takes a new sample while the old result waits.
// When the receiver stalls, the result holds and the input register holds
// its sample; sample.ready drops only when both are full.
// Reset puts the profile at the first heat stage with both counters at
// zero, the sparge alarm armed and the registers at their default profile.
// Register writes take effect from the next processed sample.
// The done stage lasts until reset.
module step_mash_temperature_sequencer import smts_pkg::*; #(
	parameter int COUNTER_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	smts_in_if.sink    sample,
	smts_out_if.source result,
	smts_cfg_if.sink   cfg
);

	`include "step_mash_temperature_sequencer_macros.svh"

	localparam int CW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

	// profile registers
	logic [6:0] target_one_q, target_two_q, target_three_q;
	logic [7:0] hold_one_q, hold_two_q, hold_three_q, alarm_lead_q;

	// pipeline and state
	logic                    s1_valid_q;
	sample_t                 s1_data;
	logic                    res_valid_q;
	result_t                 res_q;
	stage_t                  stage_q, stage_d;
	logic [COUNTER_BITS-1:0] sparge_q, sparge_inc, sparge_d;
	logic                    armed_q;

	logic                    adv;
	logic [6:0]              tgt;
	logic [7:0]              hold_min;
	logic [16:0]             tgt_milli;
	logic                    above;
	logic [9:0]              total_min, diff_min;
	logic [15:0]             alarm_lim;
	logic [13:0]             hold_lim;
	logic                    in_sparge, in_hold, alarm, hold_end, clr;
	logic                    heater, prompt, done;
	hold_ctl_t               hold_ctl;
	logic [COUNTER_BITS-1:0] hold_cnt;
	logic [4:0]              hours;
	logic [5:0]              minutes, secs;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_one_q   <= TARGET_ONE_RST;
			target_two_q   <= TARGET_TWO_RST;
			target_three_q <= TARGET_THREE_RST;
			hold_one_q     <= HOLD_ONE_RST;
			hold_two_q     <= HOLD_TWO_RST;
			hold_three_q   <= HOLD_THREE_RST;
			alarm_lead_q   <= ALARM_LEAD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.addr)
				CFG_TARGET_ONE:   target_one_q   <= cfg.data.wdata[6:0];
				CFG_TARGET_TWO:   target_two_q   <= cfg.data.wdata[6:0];
				CFG_TARGET_THREE: target_three_q <= cfg.data.wdata[6:0];
				CFG_HOLD_ONE:     hold_one_q     <= cfg.data.wdata;
				CFG_HOLD_TWO:     hold_two_q     <= cfg.data.wdata;
				CFG_HOLD_THREE:   hold_three_q   <= cfg.data.wdata;
				CFG_ALARM_LEAD:   alarm_lead_q   <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

	// handshake: advance the input register into the result register
	assign adv          = s1_valid_q && (!res_valid_q || result.ready);
	assign sample.ready = !s1_valid_q || adv;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (sample.ready)
				s1_valid_q <= sample.valid;
			if (adv)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready)
			s1_data <= sample.data;
	end

	// targets and limits of the current stage
	always_comb begin
		tgt      = '0;
		hold_min = '0;
		unique case (stage_q)
			ST_HEAT1, ST_HOLD1: begin
				tgt      = target_one_q;
				hold_min = hold_one_q;
			end
			ST_HEAT2, ST_HOLD2: begin
				tgt      = target_two_q;
				hold_min = hold_two_q;
			end
			ST_HEAT3, ST_HOLD3: begin
				tgt      = target_three_q;
				hold_min = hold_three_q;
			end
			default: ;
		endcase
	end

	assign tgt_milli = 17'(tgt) * MILLI_PER_DEG;
	assign above     = $signed({s1_data.temp_milli[17], s1_data.temp_milli})
		> $signed({2'b00, tgt_milli});

	assign total_min = 10'(hold_one_q) + 10'(hold_two_q) + 10'(hold_three_q);
	assign diff_min  = (total_min > 10'(alarm_lead_q)) ? total_min - 10'(alarm_lead_q) : '0;
	assign alarm_lim = (16'(diff_min) << 6) - (16'(diff_min) << 2);
	assign hold_lim  = (14'(hold_min) << 6) - (14'(hold_min) << 2);

	assign in_sparge = (stage_q != ST_HEAT1) && (stage_q != ST_MALT) && (stage_q != ST_DONE);
	assign in_hold   = (stage_q == ST_HOLD1) || (stage_q == ST_HOLD2) || (stage_q == ST_HOLD3);

	assign sparge_inc = (in_sparge && s1_data.second_tick && (sparge_q != {COUNTER_BITS{1'b1}}))
		? sparge_q + 1'b1 : sparge_q;
	assign alarm    = in_sparge && armed_q && (CW'(sparge_inc) >= CW'(alarm_lim));
	assign hold_end = CW'(hold_cnt) >= CW'(hold_lim);

	// stage sequencing for the item in the input register
	always_comb begin
		stage_d  = stage_q;
		sparge_d = sparge_inc;
		clr      = 1'b0;
		heater   = 1'b0;
		prompt   = 1'b0;
		done     = 1'b0;
		unique case (stage_q)
			ST_HEAT1, ST_HEAT2, ST_HEAT3: begin
				heater = !above;
				if (above) begin
					clr = 1'b1;
					unique case (stage_q)
						ST_HEAT1: stage_d = ST_MALT;
						ST_HEAT2: stage_d = ST_HOLD2;
						default:  stage_d = ST_HOLD3;
					endcase
				end
			end
			ST_MALT: begin
				prompt = 1'b1;
				if (s1_data.button_pressed) begin
					clr      = 1'b1;
					sparge_d = '0;
					stage_d  = ST_HOLD1;
				end
			end
			ST_HOLD1, ST_HOLD2, ST_HOLD3: begin
				heater = !above;
				if (hold_end) begin
					clr = 1'b1;
					unique case (stage_q)
						ST_HOLD1: stage_d = ST_HEAT2;
						ST_HOLD2: stage_d = ST_HEAT3;
						default:  stage_d = ST_DONE;
					endcase
				end
			end
			default: done = 1'b1;
		endcase
	end

	assign hold_ctl = '{step: adv, tick: in_hold && s1_data.second_tick, clear: clr};

	smts_hold_timer #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_hold_timer (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (hold_ctl),
		.count_next   (hold_cnt),
		.hours_next   (hours),
		.minutes_next (minutes),
		.secs_next    (secs)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q  <= ST_HEAT1;
			sparge_q <= '0;
			armed_q  <= 1'b1;
		end else if (adv) begin
			stage_q  <= stage_d;
			sparge_q <= sparge_d;
			if (alarm)
				armed_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.heater_on    <= heater;
			res_q.malt_prompt  <= prompt;
			res_q.sparge_alarm <= alarm;
			res_q.stage        <= stage_q;
			res_q.hold_hours   <= in_hold ? hours : '0;
			res_q.hold_minutes <= in_hold ? minutes : '0;
			res_q.hold_secs    <= in_hold ? secs : '0;
			res_q.done_res     <= done;
		end
	end

	`SMTS_ASSERT_NEXT(a_alarm_once, adv && alarm, !armed_q, "sparge alarm still armed after firing")
	`SMTS_ASSERT_NEXT(a_done_sticks, stage_q == ST_DONE, stage_q == ST_DONE, "left the done stage")
	`SMTS_ASSERT_NOW(a_prompt_stage, res_valid_q,
		res_q.malt_prompt == (res_q.stage == ST_MALT), "malt prompt outside malt wait")

endmodule
